// ===== rtl/adtf_pkg.sv =====
// Shared constants and helpers for the ASCII decimal to fixed point parser.
// No dependencies.
package adtf_pkg;

  localparam int INT_BITS    = 24;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_BITS    = INT_BITS + FRAC_BITS;
  localparam int MAX_CHARS   = 256;
  localparam int CNT_BITS    = $clog2(MAX_CHARS + 1);
  localparam int FRAC_DIGITS = 6;
  localparam int FACC_BITS   = 25;
  localparam int FCNT_BITS   = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef logic [FACC_BITS-1:0] facc_t;

  // round(2^24 / 10^(k+1)) for fraction digit position k
  function automatic facc_t frac_weight(input logic [FCNT_BITS-1:0] k);
    facc_t w;
    begin
      case (k)
        3'd0:    w = facc_t'(1677722);
        3'd1:    w = facc_t'(167772);
        3'd2:    w = facc_t'(16777);
        3'd3:    w = facc_t'(1678);
        3'd4:    w = facc_t'(168);
        3'd5:    w = facc_t'(17);
        3'd6:    w = facc_t'(2);
        default: w = '0;
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/ascii_decimal_to_fixed.sv =====
// Top level: parses the first unsigned decimal number of a byte string into Q24.16.
// Depends on adtf_pkg.
//
//  channel | ports                                   | word
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_char_code        | one character byte
//  out     | out_valid, out_ready, out_value_q16,    | parsed value, one per NUL
//          | out_saturated, out_has_digits           |
//
// One character per cycle sustained. A word is caught in an input register,
// then one pass of multiply-by-ten-add (integer) or weight-add (fraction)
// updates the parse state; a NUL also loads the result register.
// out_valid and the result ports are driven from the result register.
// rst_n is synchronous, active low; it clears the parse state and both valids.
// A stalled result blocks only a NUL in the input register; other characters
// keep flowing into the parse state.
module ascii_decimal_to_fixed
  import adtf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_BITS-1:0] out_value_q16,
  output logic                out_saturated,
  output logic                out_has_digits
);

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_INT    = 2'd1;
  localparam logic [1:0] PH_FRAC   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [INT_BITS-1:0] INT_MAX = '1;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;

  // parse state
  logic [1:0]           phase_r,    phase_nxt;
  logic [INT_BITS-1:0]  int_acc_r,  int_acc_nxt;
  facc_t                frac_acc_r, frac_acc_nxt;
  logic [FCNT_BITS-1:0] frac_cnt_r, frac_cnt_nxt;
  logic [CNT_BITS-1:0]  char_cnt_r, char_cnt_nxt;
  logic                 ovf_r,      ovf_nxt;

  // result register
  logic                out_valid_r;
  logic [VAL_BITS-1:0] out_value_r;
  logic                out_sat_r;
  logic                out_has_r;

  logic                 is_nul, is_digit, is_sep, advance, emit;
  logic [3:0]           digit;
  logic [INT_BITS-1:0]  int_base;
  logic [INT_BITS+3:0]  int_prod;
  logic                 int_over;
  facc_t                frac_sum;
  logic [FACC_BITS:0]   frac_rnd;
  logic [VAL_BITS:0]    total;
  logic [VAL_BITS-1:0]  res_value;
  logic                 res_sat;

  assign is_nul   = (s1_char_r == CH_NUL);
  assign is_digit = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign is_sep   = (s1_char_r == CH_DOT) || (s1_char_r == CH_COMMA);
  assign digit    = s1_char_r[3:0];

  // a NUL needs a free result slot; anything else always moves on
  assign advance  = s1_valid_r && (!is_nul || !out_valid_r || out_ready);
  assign emit     = advance && is_nul;
  assign in_ready = !s1_valid_r || advance;

  // integer digit: acc*10 + d, clamp on overflow
  assign int_base = (phase_r == PH_BEFORE) ? '0 : int_acc_r;
  assign int_prod = {1'b0, int_base, 3'b000} + {3'b000, int_base, 1'b0}
                  + {{INT_BITS{1'b0}}, digit};
  assign int_over = (phase_r != PH_BEFORE && ovf_r) || (int_prod[INT_BITS+3:INT_BITS] != '0);

  // fraction digit: add weighted digit, sum kept to 25 bits
  assign frac_sum = frac_acc_r + facc_t'(digit * frac_weight(frac_cnt_r));

  // result: round fraction sum to 16 bits, clamp on carry out of the top
  assign frac_rnd  = {1'b0, frac_acc_r} + (FACC_BITS+1)'(128);
  assign total     = {1'b0, int_acc_r, {FRAC_BITS{1'b0}}}
                   + (VAL_BITS+1)'(frac_rnd[FACC_BITS:8]);
  assign res_sat   = ovf_r || total[VAL_BITS];
  assign res_value = total[VAL_BITS] ? '1 : total[VAL_BITS-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    frac_cnt_nxt = frac_cnt_r;
    char_cnt_nxt = char_cnt_r;
    ovf_nxt      = ovf_r;
    if (advance) begin
      if (is_nul) begin
        phase_nxt    = PH_BEFORE;
        int_acc_nxt  = '0;
        frac_acc_nxt = '0;
        frac_cnt_nxt = '0;
        char_cnt_nxt = '0;
        ovf_nxt      = 1'b0;
      end else if (char_cnt_r < CNT_BITS'(MAX_CHARS)) begin
        char_cnt_nxt = char_cnt_r + 1'b1;
        case (phase_r)
          PH_BEFORE, PH_INT: begin
            if (is_digit) begin
              phase_nxt = PH_INT;
              if (int_over) begin
                int_acc_nxt = INT_MAX;
                ovf_nxt     = 1'b1;
              end else begin
                int_acc_nxt = int_prod[INT_BITS-1:0];
              end
            end else if (phase_r == PH_INT) begin
              phase_nxt = is_sep ? PH_FRAC : PH_DONE;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (frac_cnt_r < FCNT_BITS'(FRAC_DIGITS)) begin
                frac_acc_nxt = frac_sum;
                frac_cnt_nxt = frac_cnt_r + 1'b1;
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_BEFORE;
      int_acc_r   <= '0;
      frac_acc_r  <= '0;
      frac_cnt_r  <= '0;
      char_cnt_r  <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      phase_r    <= phase_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
    end
    if (emit) begin
      out_value_r <= res_value;
      out_sat_r   <= res_sat;
      out_has_r   <= (phase_r != PH_BEFORE);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_q16  = out_value_r;
  assign out_saturated  = out_sat_r;
  assign out_has_digits = out_has_r;

  // no digit seen means an all-zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_value_r == '0 && !out_sat_r)
    else $error("result without digits is not zero");

  // before the number all accumulators are clear
  a_before_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BEFORE |-> int_acc_r == '0 && frac_acc_r == '0 && !ovf_r
                             && frac_cnt_r == '0)
    else $error("parse state dirty before number");

  // fraction digit count and character count stay in range
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    frac_cnt_r <= FCNT_BITS'(FRAC_DIGITS) && char_cnt_r <= CNT_BITS'(MAX_CHARS))
    else $error("counter out of range");

  // a NUL never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for ascii_decimal_to_fixed: character strings in, Q24.16 values out.
// Predicts each parsed value in SystemVerilog and checks it against the result port.
// Depends on adtf_pkg and the ascii_decimal_to_fixed RTL.
`timescale 1ns / 1ps

module testbench;
  import adtf_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // Worst honest stretch is one input gap plus one output stall plus latency.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_CHARS = 560;
  localparam int MAX_GAP = 12;
  localparam int WEIGHT_N = 7;

  // Fraction digit weights in units of 2^-24: round(2^24 / 10^k), k = 1..7
  localparam logic [FACC_BITS-1:0] DIGIT_WEIGHT [WEIGHT_N] = '{
    25'd1677722, 25'd167772, 25'd16777, 25'd1678, 25'd168, 25'd17, 25'd2
  };

  typedef enum logic [1:0] {SCAN, INT_PART, FRAC_PART, ENDED} phase_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] value;
    logic                sat;
    logic                digits;
  } parsed_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_char_code = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_BITS-1:0] out_value_q16;
  logic                out_saturated;
  logic                out_has_digits;

  logic [7:0] char_q[$];     // characters waiting to be driven
  parsed_t    parsed_q[$];   // values the parser owes us, oldest first
  int         errors = 0;
  int         idle_cycles = 0;
  int         in_wait = 0;
  bit         in_burst = 1'b0;
  int         out_stall = 0;
  bit         out_burst = 1'b0;

  // Shadow parse state
  phase_t                 ph = SCAN;
  logic [INT_BITS-1:0]    int_acc = '0;
  logic [FACC_BITS-1:0]   frac_acc = '0;
  logic [FCNT_BITS-1:0]   frac_cnt = '0;
  int unsigned            seen = 0;
  logic                   clamped = 1'b0;

  ascii_decimal_to_fixed u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_q16  (out_value_q16),
    .out_saturated  (out_saturated),
    .out_has_digits (out_has_digits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_parse();
    ph       = SCAN;
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = '0;
    seen     = 0;
    clamped  = 1'b0;
  endtask

  // Multiply-by-ten-add with clamp; once clamped, stays pinned at full scale.
  task automatic take_int_digit(input logic [3:0] d);
    longint unsigned lim;
    lim = (64'd1 << INT_BITS) - 1;
    if (clamped || int_acc > (lim - d) / 10) begin
      int_acc = '1;
      clamped = 1'b1;
    end else begin
      int_acc = INT_BITS'(int_acc * 10 + d);
    end
  endtask

  // Advance the shadow parser by one accepted character; a NUL yields a value.
  task automatic parse_char(input logic [7:0] c);
    logic [VAL_BITS:0] total;
    logic [3:0]        d;
    logic              is_digit;
    parsed_t           p;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 4'(c - CH_ZERO);
    if (c == CH_NUL) begin
      // fraction rounded half up from 2^-24 to 2^-16; the carry may overflow
      total = ((VAL_BITS + 1)'(int_acc) << FRAC_BITS)
            + (((VAL_BITS + 1)'(frac_acc) + 128) >> 8);
      p.sat = clamped;
      if (total > {VAL_BITS{1'b1}}) begin
        total = {1'b0, {VAL_BITS{1'b1}}};
        p.sat = 1'b1;
      end
      p.value  = total[VAL_BITS-1:0];
      p.digits = (ph != SCAN);
      parsed_q.push_back(p);
      clear_parse();
    end else if (seen < MAX_CHARS) begin
      seen++;
      case (ph)
        SCAN: begin
          if (is_digit) begin
            int_acc = '0;
            take_int_digit(d);
            ph = INT_PART;
          end
        end
        INT_PART: begin
          if (is_digit) take_int_digit(d);
          else if (c == CH_DOT || c == CH_COMMA) ph = FRAC_PART;
          else ph = ENDED;
        end
        FRAC_PART: begin
          if (is_digit) begin
            // digits past the table or the digit limit are swallowed
            if (frac_cnt < FRAC_DIGITS && frac_cnt < WEIGHT_N) begin
              frac_acc = frac_acc + d * DIGIT_WEIGHT[frac_cnt];
              frac_cnt = frac_cnt + 1'b1;
            end
          end else begin
            ph = ENDED;
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic logic [7:0] digit_char();
    // lean on nines: they drive the clamp and the rounding carry
    return ($urandom_range(0, 3) == 0) ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  task automatic push_str(input string s);
    foreach (s[i]) char_q.push_back(s[i]);
    char_q.push_back(CH_NUL);
  endtask

  // One random string: mostly well-formed numbers with random content,
  // some pure noise, some fraction-only or junk-terminated.
  task automatic add_random_string();
    int kind;
    int n;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) char_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) char_q.push_back(non_digit());
      if (kind == 1) n = 0;                          // separator seen before any digit
      else if (kind < 5) n = $urandom_range(8, 12);  // often large enough to clamp
      else n = $urandom_range(1, 7);
      repeat (n) char_q.push_back(digit_char());
      if ($urandom_range(0, 3) != 0) begin
        char_q.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        n = $urandom_range(0, 9);
        repeat (n) char_q.push_back(digit_char());
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) char_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    char_q.push_back(CH_NUL);
  endtask

  // Driver: one word per handshake, random gap drawn per word, with
  // occasional back-to-back bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) parse_char(in_char_code);
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (char_q.size() != 0) begin
        in_valid     <= 1'b1;
        in_char_code <= char_q.pop_front();
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_wait <= in_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction,
  // then draws how long to hold ready low before taking the next one.
  always @(posedge clk) begin : mon_p
    parsed_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: value %h sat %b digits %b",
                     out_value_q16, out_saturated, out_has_digits);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          if (out_value_q16 !== want.value || out_saturated !== want.sat ||
              out_has_digits !== want.digits) begin
            if (errors < 10)
              $display("mismatch: value %h/%h sat %b/%b digits %b/%b (expected/actual)",
                       want.value, out_value_q16, want.sat, out_saturated,
                       want.digits, out_has_digits);
            errors++;
          end
        end
        if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int base;
    int n;
    clear_parse();

    // Directed strings
    push_str("");                   // empty string
    push_str("abc");                // no digit at all
    push_str("0");
    push_str("16777215");           // largest integer part
    push_str("16777216");           // one past: clamps
    push_str("123456789012");       // clamps, later digits keep it pinned
    push_str("12.5");
    push_str("3,14159265");         // comma separator, extra fraction digits
    push_str("0.999999");           // rounding carry into the integer
    push_str("16777215.999999");    // carry past full scale: clamped
    push_str("x12y34");             // other character ends the number
    push_str(".5");                 // separator before any digit is skipped
    push_str("12.3.4");
    push_str("99.");
    char_q.push_back("8");          // high-bit bytes end the number
    char_q.push_back(8'hFF);
    char_q.push_back(8'h80);
    char_q.push_back(CH_NUL);

    // Long strings: the number straddles the character limit
    repeat (3) begin
      n = $urandom_range(MAX_CHARS - 6, MAX_CHARS + 2);
      repeat (n) char_q.push_back(non_digit());
      repeat (8) char_q.push_back(digit_char());
      char_q.push_back(CH_NUL);
    end

    base = char_q.size();
    while (char_q.size() - base < RANDOM_CHARS) add_random_string();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so driver updates have settled
    while (char_q.size() != 0 || in_valid || parsed_q.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/adtf_pkg.sv
rtl/ascii_decimal_to_fixed.sv
tb/testbench.sv
